// ===== src/rarsf_pkg.sv =====
`timescale 1ns / 1ps
// Package for the range-add / range-sum Fenwick tree.
// Holds request and response types, field widths and codes; no dependencies.
package rarsf_pkg;

  localparam int unsigned POS_W    = 10;
  localparam int unsigned VAL_W    = 64;
  localparam int unsigned MUL_W    = POS_W + 1;
  localparam int unsigned SIZE_DEF = 1024;

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_SUM = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [POS_W-1:0]   left;
    logic [POS_W-1:0]   right;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] total;
    logic               status;
  } rsp_t;

endpackage

// ===== src/rarsf_ram.sv =====
`timescale 1ns / 1ps
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on nothing; depth and width are handed down from the top level.
module rarsf_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/range_add_range_sum_fenwick.sv =====
`timescale 1ns / 1ps
// Top level of the range-add / range-sum Fenwick tree.
// Depends on rarsf_pkg and rarsf_ram.
//
// After reset the block clears both coefficient memories, one entry a cycle,
// and stalls requests meanwhile. Each request is then run as one or two
// prefix walks (at right, and at left-1 when left is nonzero); each walk
// visits the down chain and the up chain of the tree, and every visited node
// goes through a memory read, two 32-bit halves through one shared
// multiplier, and a write-back or accumulate. A walk visits at most
// log2(SIZE) + 1 nodes. A bad range skips the walks and goes straight to
// the finish step. One request is in flight at a time; the result register
// lets the next request enter while a result waits to be taken.
module range_add_range_sum_fenwick #(
  parameter int unsigned SIZE = rarsf_pkg::SIZE_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rarsf_pkg::req_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rarsf_pkg::rsp_t out_data_o
);
  import rarsf_pkg::*;

  localparam int unsigned AW = $clog2(SIZE);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned XW = (CW > MUL_W) ? CW : MUL_W;
  localparam int unsigned PW = 32 + MUL_W;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_M0   = 3'd3;
  localparam logic [2:0] ST_M1   = 3'd4;
  localparam logic [2:0] ST_WB   = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic             kind_q, kind_d;
  logic             bad_q, bad_d;
  logic             second_q, second_d;
  logic             has_left_q, has_left_d;
  logic             up_q, up_d;
  logic [AW-1:0]    r_q, r_d;
  logic [AW-1:0]    lm1_q, lm1_d;
  logic [CW-1:0]    i_q, i_d;
  logic [VAL_W-1:0] v_q, v_d;
  logic [VAL_W-1:0] acc_q, acc_d;
  logic [PW-1:0]    p0_q, p0_d;
  logic [PW-1:0]    p1_q, p1_d;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q, out_d;

  logic             accept;
  logic             pi_we, sl_we, rd_en;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] pi_wdata, sl_wdata, pi_rdata, sl_rdata;
  logic [CW-1:0]    i_inc, base, rx, up_start, up_next;
  logic [XW-1:0]    m_full;
  logic [MUL_W-1:0] m;
  logic [VAL_W-1:0] x;
  logic [31:0]      x_half;
  logic [PW-1:0]    mul_out;
  logic [VAL_W-1:0] prod;
  logic             bad_in;

  rarsf_ram #(.Depth(SIZE), .Width(VAL_W)) u_pi_ram (
    .clk_i   (clk_i),
    .we_i    (pi_we),
    .waddr_i (waddr),
    .wdata_i (pi_wdata),
    .re_i    (rd_en),
    .raddr_i (i_q[AW-1:0]),
    .rdata_o (pi_rdata)
  );

  rarsf_ram #(.Depth(SIZE), .Width(VAL_W)) u_sl_ram (
    .clk_i   (clk_i),
    .we_i    (sl_we),
    .waddr_i (waddr),
    .wdata_i (sl_wdata),
    .re_i    (rd_en),
    .raddr_i (i_q[AW-1:0]),
    .rdata_o (sl_rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign bad_in = (in_data_i.left > in_data_i.right) ||
                  (32'(in_data_i.right) >= 32'(SIZE));

  assign i_inc    = i_q + CW'(1);
  assign base     = i_q & i_inc;
  assign rx       = {1'b0, r_q};
  assign up_start = rx | (rx + CW'(1));
  assign up_next  = i_q | i_inc;
  assign m_full   = (up_q ? XW'(rx) : XW'(i_q)) - XW'(base) + XW'(1);
  assign m        = m_full[MUL_W-1:0];
  assign x        = (kind_q == KIND_ADD) ? v_q : sl_rdata;
  assign x_half   = (state_q == ST_M0) ? x[31:0] : x[63:32];
  assign mul_out  = {{MUL_W{1'b0}}, x_half} * {{32{1'b0}}, m};
  assign prod     = VAL_W'(p0_q) + {p1_q[31:0], 32'b0};
  assign rd_en    = (state_q == ST_RD);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    kind_d      = kind_q;
    bad_d       = bad_q;
    second_d    = second_q;
    has_left_d  = has_left_q;
    up_d        = up_q;
    r_d         = r_q;
    lm1_d       = lm1_q;
    i_d         = i_q;
    v_d         = v_q;
    acc_d       = acc_q;
    p0_d        = p0_q;
    p1_d        = p1_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    pi_we       = 1'b0;
    sl_we       = 1'b0;
    waddr       = i_q[AW-1:0];
    pi_wdata    = pi_rdata + prod;
    sl_wdata    = sl_rdata + v_q;
    case (state_q)
      ST_CLR: begin
        pi_we    = 1'b1;
        sl_we    = 1'b1;
        waddr    = clr_q;
        pi_wdata = '0;
        sl_wdata = '0;
        clr_d    = clr_q + AW'(1);
        if (clr_q == AW'(SIZE - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          kind_d     = in_data_i.kind;
          bad_d      = bad_in;
          second_d   = 1'b0;
          has_left_d = (in_data_i.left != '0);
          up_d       = 1'b0;
          r_d        = AW'(in_data_i.right);
          lm1_d      = AW'(in_data_i.left) - AW'(1);
          i_d        = CW'(in_data_i.right);
          v_d        = in_data_i.value;
          acc_d      = '0;
          state_d    = bad_in ? ST_FIN : ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_M0;
      end
      ST_M0: begin
        p0_d    = mul_out;
        state_d = ST_M1;
      end
      ST_M1: begin
        p1_d    = mul_out;
        state_d = ST_WB;
      end
      ST_WB: begin
        if (kind_q == KIND_ADD) begin
          sl_we = !up_q;
          pi_we = up_q;
        end else if (up_q) begin
          acc_d = acc_q + prod;
        end else begin
          acc_d = acc_q + pi_rdata + prod;
        end
        state_d = ST_RD;
        if (!up_q && base != '0) begin
          i_d = base - CW'(1);
        end else if (!up_q && up_start < CW'(SIZE)) begin
          up_d = 1'b1;
          i_d  = up_start;
        end else if (up_q && up_next < CW'(SIZE)) begin
          i_d = up_next;
        end else if (!second_q && has_left_q) begin
          // start the walk at left-1 with the negated amount
          second_d = 1'b1;
          up_d     = 1'b0;
          r_d      = lm1_q;
          i_d      = {1'b0, lm1_q};
          v_d      = '0 - v_q;
          acc_d    = '0 - acc_d;
        end else begin
          if (second_q) begin
            acc_d = '0 - acc_d;
          end
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_d.status = bad_q ? STATUS_BAD : STATUS_DONE;
          out_d.total  = (bad_q || kind_q == KIND_ADD) ? '0 : acc_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    bad_q      <= bad_d;
    second_q   <= second_d;
    has_left_q <= has_left_d;
    up_q       <= up_d;
    r_q        <= r_d;
    lm1_q      <= lm1_d;
    i_q        <= i_d;
    v_q        <= v_d;
    acc_q      <= acc_d;
    p0_q       <= p0_d;
    p1_q       <= p1_d;
    out_q      <= out_d;
  end

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_BAD |-> out_data_o.total == '0)
    else $error("bad range result carries a nonzero total");

  a_we_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pi_we || sl_we) |-> (state_q == ST_WB || state_q == ST_CLR))
    else $error("memory write outside write-back or clearing");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD |-> i_q < CW'(SIZE))
    else $error("tree index out of range");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("result raised outside finish step");

  a_add_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WB && kind_q == KIND_ADD |-> (pi_we != sl_we))
    else $error("add must update exactly one coefficient memory");

endmodule
